/* rtl/tce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

	localparam int DATA_WIDTH    = 32;
	localparam int DEF_NUM_REGS  = 16;
	localparam int DEF_MEM_WORDS = 256;
	localparam int DEF_PC_WIDTH  = 16;

	typedef logic [3:0] opcode_t;
	typedef logic [1:0] status_t;
	typedef logic [4:0] cost_t;

	localparam opcode_t OP_MOV0 = 4'd0;
	localparam opcode_t OP_MOV1 = 4'd1;
	localparam opcode_t OP_MOV2 = 4'd2;
	localparam opcode_t OP_MOV3 = 4'd3;
	localparam opcode_t OP_ADD  = 4'd4;
	localparam opcode_t OP_SUB  = 4'd5;
	localparam opcode_t OP_JZ   = 4'd6;
	localparam opcode_t OP_MUL  = 4'd7;
	localparam opcode_t OP_MOV4 = 4'd8;
	localparam opcode_t OP_MOV5 = 4'd9;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_ADDR = 2'd1;
	localparam status_t ST_BAD_OP   = 2'd2;

	function automatic cost_t cost_of(opcode_t f);
		cost_t c;
		unique case (f)
			OP_MOV0: c = 5'd8;
			OP_MOV1: c = 5'd8;
			OP_MOV2: c = 5'd12;
			OP_MOV3: c = 5'd6;
			OP_ADD:  c = 5'd4;
			OP_SUB:  c = 5'd4;
			OP_JZ:   c = 5'd12;
			OP_MUL:  c = 5'd30;
			OP_MOV4: c = 5'd2;
			OP_MOV5: c = 5'd12;
			default: c = 5'd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/tce_regfile.sv */
`timescale 1ns / 1ps
`default_nettype none

module tce_regfile #(
	parameter int NUM_REGS = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                rd_en,
	input  wire  [$clog2(NUM_REGS)-1:0]        rd_addr_a,
	input  wire  [$clog2(NUM_REGS)-1:0]        rd_addr_b,
	output logic [tce_pkg::DATA_WIDTH-1:0]     rd_data_a,
	output logic [tce_pkg::DATA_WIDTH-1:0]     rd_data_b,
	input  wire                                wr_en,
	input  wire  [$clog2(NUM_REGS)-1:0]        wr_addr,
	input  wire  [tce_pkg::DATA_WIDTH-1:0]     wr_data
);
	import tce_pkg::*;

	logic [DATA_WIDTH-1:0] ram [NUM_REGS];
	logic [NUM_REGS-1:0]   vld_q;
	logic [DATA_WIDTH-1:0] rdata_a_q;
	logic [DATA_WIDTH-1:0] rdata_b_q;

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram[wr_addr] <= wr_data;
		end
	end

	// write-first: a read at the edge of a write to the same entry sees the new value
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr_a) begin
				rdata_a_q <= wr_data;
			end else begin
				rdata_a_q <= vld_q[rd_addr_a] ? ram[rd_addr_a] : '0;
			end
			if (wr_en && wr_addr == rd_addr_b) begin
				rdata_b_q <= wr_data;
			end else begin
				rdata_b_q <= vld_q[rd_addr_b] ? ram[rd_addr_b] : '0;
			end
		end
	end

	assign rd_data_a = rdata_a_q;
	assign rd_data_b = rdata_b_q;

endmodule

`default_nettype wire

/* rtl/tce_dmem.sv */
`timescale 1ns / 1ps
`default_nettype none

module tce_dmem #(
	parameter int MEM_WORDS = 256
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                rd_en,
	input  wire  [$clog2(MEM_WORDS)-1:0]       rd_addr,
	output logic [tce_pkg::DATA_WIDTH-1:0]     rd_data,
	input  wire                                wr_en,
	input  wire  [$clog2(MEM_WORDS)-1:0]       wr_addr,
	input  wire  [tce_pkg::DATA_WIDTH-1:0]     wr_data
);
	import tce_pkg::*;

	logic [DATA_WIDTH-1:0] ram [MEM_WORDS];
	logic [MEM_WORDS-1:0]  vld_q;
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rdata_q <= wr_data;
			end else begin
				rdata_q <= vld_q[rd_addr] ? ram[rd_addr] : '0;
			end
		end
	end

	assign rd_data = rdata_q;

endmodule

`default_nettype wire

/* rtl/tiny_cpu_execute_unit.sv */
// Execute stage of a small register machine: one decoded instruction per item
// (func, dest_reg, operand) and one result per instruction (new PC, cycle cost,
// status and the register or memory write it made).
// Both channels transfer when valid is high and stall is low at a clock edge.
// The register file is read at the transfer edge; the next cycle computes the
// result and, when the output register is free, writes back and loads the result.
// An indirect load (MOV5) with its pointer in range first reads memory at the
// address that comes out of the register file read, and takes no new instruction
// until both dependent reads are done. Throughput is otherwise one instruction
// per cycle while the output register is free; back-to-back dependent
// instructions run at full rate through write-first bypass on both memories.
// While result_stall holds a finished result, the instruction behind it waits
// in the execute register and item_stall is raised; nothing is lost.
// Reset clears the PC and marks all registers and memory words as zero at once,
// with valid bits per entry; no clearing pass, items are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module tiny_cpu_execute_unit #(
	parameter int NUM_REGS  = tce_pkg::DEF_NUM_REGS,
	parameter int MEM_WORDS = tce_pkg::DEF_MEM_WORDS,
	parameter int PC_WIDTH  = tce_pkg::DEF_PC_WIDTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_stall,
	input  wire  [3:0]         func,
	input  wire  [3:0]         dest_reg,
	input  wire  [7:0]         operand,
	output logic               result_valid,
	input  wire                result_stall,
	output logic [15:0]        next_pc,
	output logic [4:0]         cycle_cost,
	output logic [1:0]         status,
	output logic               reg_write_valid,
	output logic [3:0]         reg_write_index,
	output logic signed [31:0] reg_write_value,
	output logic               mem_write_valid,
	output logic [7:0]         mem_write_addr,
	output logic signed [31:0] mem_write_value
);
	import tce_pkg::*;

	localparam int RW = $clog2(NUM_REGS);
	localparam int AW = $clog2(MEM_WORDS);

	// constant reduction tables for register and direct addresses
	logic [RW-1:0] idx_tab  [16];
	logic [AW-1:0] addr_tab [256];

	for (genvar i = 0; i < 16; i++) begin : g_idx
		assign idx_tab[i] = RW'(i % NUM_REGS);
	end
	for (genvar j = 0; j < 256; j++) begin : g_addr
		assign addr_tab[j] = AW'(j % MEM_WORDS);
	end

	logic                  accept;
	logic                  complete;
	logic                  out_free;
	logic [RW-1:0]         rn_in;
	logic [RW-1:0]         rm_in;

	logic                  valid_s1;
	opcode_t               func_s1;
	logic [RW-1:0]         rn_s1;
	logic [7:0]            op_s1;
	logic                  phase_s1;

	logic [PC_WIDTH-1:0]   pc_q;
	logic [PC_WIDTH-1:0]   pc_inc;
	logic [PC_WIDTH-1:0]   pc_new;

	logic [DATA_WIDTH-1:0] a;
	logic [DATA_WIDTH-1:0] b;
	logic [DATA_WIDTH-1:0] md;
	logic [DATA_WIDTH-1:0] prod;
	logic                  a_ok;
	logic                  b_ok;

	logic                  rw;
	logic                  mw;
	logic [DATA_WIDTH-1:0] rw_val;
	logic [DATA_WIDTH-1:0] mw_val;
	logic [AW-1:0]         mw_addr;
	status_t               st;
	logic                  need_ind;
	logic                  done;
	logic                  ind_issue;
	logic                  dm_rd_en;
	logic [AW-1:0]         dm_rd_addr;

	logic                  valid_q;
	logic [15:0]           pc_out_q;
	cost_t                 cost_q;
	status_t               status_q;
	logic                  rw_q;
	logic [3:0]            rw_idx_q;
	logic [31:0]           rw_val_q;
	logic                  mw_q;
	logic [7:0]            mw_addr_q;
	logic [31:0]           mw_val_q;

	assign rn_in = idx_tab[dest_reg];
	assign rm_in = (func == OP_MOV2 || func == OP_MOV5) ? idx_tab[operand[3:0]]
	                                                      : idx_tab[operand[7:4]];

	assign out_free   = !valid_q || !result_stall;
	assign done       = valid_s1 && !need_ind;
	assign ind_issue  = valid_s1 && need_ind;
	assign complete   = done && out_free;
	assign item_stall = valid_s1 && !complete;
	assign accept     = item_valid && !item_stall;

	// second read of an indirect load takes the memory port, so no transfer then
	assign dm_rd_en   = accept || ind_issue;
	assign dm_rd_addr = ind_issue ? b[AW-1:0] : addr_tab[operand];

	tce_regfile #(
		.NUM_REGS (NUM_REGS)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (rn_in),
		.rd_addr_b (rm_in),
		.rd_data_a (a),
		.rd_data_b (b),
		.wr_en     (complete && rw),
		.wr_addr   (rn_s1),
		.wr_data   (rw_val)
	);

	tce_dmem #(
		.MEM_WORDS (MEM_WORDS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (dm_rd_en),
		.rd_addr (dm_rd_addr),
		.rd_data (md),
		.wr_en   (complete && mw),
		.wr_addr (mw_addr),
		.wr_data (mw_val)
	);

	assign pc_inc = pc_q + PC_WIDTH'(1);
	assign prod   = a * b;
	assign a_ok   = a < DATA_WIDTH'(MEM_WORDS);
	assign b_ok   = b < DATA_WIDTH'(MEM_WORDS);

	always_comb begin
		rw       = 1'b0;
		mw       = 1'b0;
		rw_val   = '0;
		mw_val   = '0;
		mw_addr  = '0;
		st       = ST_OK;
		need_ind = 1'b0;
		pc_new   = pc_inc;
		unique case (func_s1)
			OP_MOV0: begin
				rw     = 1'b1;
				rw_val = md;
			end
			OP_MOV1: begin
				mw      = 1'b1;
				mw_addr = addr_tab[op_s1];
				mw_val  = a;
			end
			OP_MOV2: begin
				if (!a_ok) begin
					st = ST_BAD_ADDR;
				end else begin
					mw      = 1'b1;
					mw_addr = a[AW-1:0];
					mw_val  = b;
				end
			end
			OP_MOV3: begin
				rw     = 1'b1;
				rw_val = DATA_WIDTH'(op_s1);
			end
			OP_ADD: begin
				rw     = 1'b1;
				rw_val = a + b;
			end
			OP_SUB: begin
				rw     = 1'b1;
				rw_val = a - b;
			end
			OP_JZ: begin
				if (a == '0) begin
					pc_new = pc_inc + PC_WIDTH'($signed(op_s1));
				end
			end
			OP_MUL: begin
				rw     = 1'b1;
				rw_val = prod;
			end
			OP_MOV4: begin
				rw     = 1'b1;
				rw_val = b;
			end
			OP_MOV5: begin
				if (!b_ok) begin
					st = ST_BAD_ADDR;
				end else if (!phase_s1) begin
					need_ind = 1'b1;
				end else begin
					rw     = 1'b1;
					rw_val = md;
				end
			end
			default: begin
				st = ST_BAD_OP;
			end
		endcase
		if (st != ST_OK) begin
			pc_new = pc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			phase_s1 <= 1'b0;
		end else if (ind_issue) begin
			phase_s1 <= 1'b1;
		end else if (complete) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			rn_s1   <= rn_in;
			op_s1   <= operand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (complete) begin
			pc_q <= pc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (complete) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			pc_out_q  <= 16'(pc_new);
			cost_q    <= cost_of(func_s1);
			status_q  <= st;
			rw_q      <= rw;
			rw_idx_q  <= rw ? 4'(rn_s1) : 4'd0;
			rw_val_q  <= 32'(rw_val);
			mw_q      <= mw;
			mw_addr_q <= 8'(mw_addr);
			mw_val_q  <= 32'(mw_val);
		end
	end

	assign result_valid    = valid_q;
	assign next_pc         = pc_out_q;
	assign cycle_cost      = cost_q;
	assign status          = status_q;
	assign reg_write_valid = rw_q;
	assign reg_write_index = rw_idx_q;
	assign reg_write_value = rw_val_q;
	assign mem_write_valid = mw_q;
	assign mem_write_addr  = mw_addr_q;
	assign mem_write_value = mw_val_q;

endmodule

`default_nettype wire

/* tb/exec_check_pkg.sv */
`timescale 1ns / 1ps

package exec_check_pkg;

	import tce_pkg::*;

	// what one executed instruction should report
	typedef struct packed {
		logic [15:0] next_pc;
		cost_t       cost;
		status_t     status;
		logic        reg_wr;
		logic [3:0]  reg_idx;
		logic [31:0] reg_val;
		logic        mem_wr;
		logic [7:0]  mem_loc;
		logic [31:0] mem_val;
	} exec_result_t;

	class exec_scoreboard;
		logic [31:0]  regs [DEF_NUM_REGS];
		logic [31:0]  dmem [DEF_MEM_WORDS];
		logic [15:0]  pc;
		exec_result_t expected_q[$];
		int errors;
		int checked;
		int faults;
		int taken;
		int mem_writes;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			pc = '0;
			errors = 0;
			checked = 0;
			faults = 0;
			taken = 0;
			mem_writes = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		// executes one accepted instruction on the shadow state
		function void note_instr(opcode_t f, logic [3:0] rn, logic [7:0] opnd);
			exec_result_t r;
			logic [3:0]   rm_hi;
			logic [3:0]   rm_lo;
			logic [31:0]  ptr;
			logic [15:0]  nxt;
			r = '0;
			rm_hi = opnd[7:4];
			rm_lo = opnd[3:0];
			nxt = pc + 16'd1;
			r.status = ST_OK;
			case (f)
				OP_MOV0: begin
					r.cost = 5'd8;
					r.reg_wr = 1'b1;
					r.reg_idx = rn;
					r.reg_val = dmem[opnd];
				end
				OP_MOV1: begin
					r.cost = 5'd8;
					r.mem_wr = 1'b1;
					r.mem_loc = opnd;
					r.mem_val = regs[rn];
				end
				OP_MOV2: begin
					r.cost = 5'd12;
					ptr = regs[rn];
					// negative pointers are huge when unsigned
					if (ptr >= DEF_MEM_WORDS) begin
						r.status = ST_BAD_ADDR;
					end else begin
						r.mem_wr = 1'b1;
						r.mem_loc = ptr[7:0];
						r.mem_val = regs[rm_lo];
					end
				end
				OP_MOV3: begin
					r.cost = 5'd6;
					r.reg_wr = 1'b1;
					r.reg_idx = rn;
					r.reg_val = {24'd0, opnd};
				end
				OP_ADD: begin
					r.cost = 5'd4;
					r.reg_wr = 1'b1;
					r.reg_idx = rn;
					r.reg_val = regs[rn] + regs[rm_hi];
				end
				OP_SUB: begin
					r.cost = 5'd4;
					r.reg_wr = 1'b1;
					r.reg_idx = rn;
					r.reg_val = regs[rn] - regs[rm_hi];
				end
				OP_JZ: begin
					r.cost = 5'd12;
					if (regs[rn] == '0) begin
						nxt = nxt + {{8{opnd[7]}}, opnd};
						taken++;
					end
				end
				OP_MUL: begin
					r.cost = 5'd30;
					r.reg_wr = 1'b1;
					r.reg_idx = rn;
					r.reg_val = regs[rn] * regs[rm_hi];
				end
				OP_MOV4: begin
					r.cost = 5'd2;
					r.reg_wr = 1'b1;
					r.reg_idx = rn;
					r.reg_val = regs[rm_hi];
				end
				OP_MOV5: begin
					r.cost = 5'd12;
					ptr = regs[rm_lo];
					if (ptr >= DEF_MEM_WORDS) begin
						r.status = ST_BAD_ADDR;
					end else begin
						r.reg_wr = 1'b1;
						r.reg_idx = rn;
						r.reg_val = dmem[ptr[7:0]];
					end
				end
				default: begin
					r.status = ST_BAD_OP;
				end
			endcase
			if (r.status != ST_OK) begin
				// a fault reports the pc it stopped at and changes nothing
				r.next_pc = pc;
				faults++;
			end else begin
				if (r.reg_wr)
					regs[r.reg_idx] = r.reg_val;
				if (r.mem_wr) begin
					dmem[r.mem_loc] = r.mem_val;
					mem_writes++;
				end
				pc = nxt;
				r.next_pc = nxt;
			end
			expected_q.push_back(r);
		endfunction

		function void cmp(string fname, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", fname, want, got);
				errors++;
			end
		endfunction

		function void check_result(exec_result_t got);
			exec_result_t want;
			if (expected_q.size() == 0) begin
				$error("result transfer with no instruction pending, next_pc %0h", got.next_pc);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			cmp("next_pc", 32'(want.next_pc), 32'(got.next_pc));
			cmp("cycle_cost", 32'(want.cost), 32'(got.cost));
			cmp("status", 32'(want.status), 32'(got.status));
			cmp("reg_write_valid", 32'(want.reg_wr), 32'(got.reg_wr));
			cmp("reg_write_index", 32'(want.reg_idx), 32'(got.reg_idx));
			cmp("reg_write_value", want.reg_val, got.reg_val);
			cmp("mem_write_valid", 32'(want.mem_wr), 32'(got.mem_wr));
			cmp("mem_write_addr", 32'(want.mem_loc), 32'(got.mem_loc));
			cmp("mem_write_value", want.mem_val, got.mem_val);
		endfunction
	endclass

endpackage

/* tb/tiny_cpu_execute_unit_tb.sv */
`timescale 1ns / 1ps

module tiny_cpu_execute_unit_tb;

	import tce_pkg::*;
	import exec_check_pkg::*;

	localparam opcode_t OP_FIRST_BAD = 4'd10;
	localparam opcode_t OP_LAST_BAD  = 4'd15;
	localparam int      TOTAL_ITEMS  = 1100;
	localparam int      LONG_HOLD    = 60;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic [3:0]         func;
	logic [3:0]         dest_reg;
	logic [7:0]         operand;
	logic               result_valid;
	logic               result_stall;
	logic [15:0]        next_pc;
	logic [4:0]         cycle_cost;
	logic [1:0]         status;
	logic               reg_write_valid;
	logic [3:0]         reg_write_index;
	logic signed [31:0] reg_write_value;
	logic               mem_write_valid;
	logic [7:0]         mem_write_addr;
	logic signed [31:0] mem_write_value;

	exec_scoreboard sb;
	int       sent;
	int       burst_left;
	int       in_stall_cycles;
	bit       hold_req;
	int       hold_left;
	rx_mode_t rx_mode;
	int       rx_mode_left;

	tiny_cpu_execute_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.dest_reg(dest_reg),
		.operand(operand),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.next_pc(next_pc),
		.cycle_cost(cycle_cost),
		.status(status),
		.reg_write_valid(reg_write_valid),
		.reg_write_index(reg_write_index),
		.reg_write_value(reg_write_value),
		.mem_write_valid(mem_write_valid),
		.mem_write_addr(mem_write_addr),
		.mem_write_value(mem_write_value)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			sb.note_instr(func, dest_reg, operand);
		if (arst_n && item_valid && item_stall)
			in_stall_cycles++;
	end

	always @(posedge clk) begin
		exec_result_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.next_pc  = next_pc;
			got.cost     = cycle_cost;
			got.status   = status;
			got.reg_wr   = reg_write_valid;
			got.reg_idx  = reg_write_index;
			got.reg_val  = reg_write_value;
			got.mem_wr   = mem_write_valid;
			got.mem_loc  = mem_write_addr;
			got.mem_val  = mem_write_value;
			sb.check_result(got);
		end
	end

	// result side: a long hold on request, otherwise a stall mode that changes now and then
	always @(negedge clk) begin
		bit s;
		s = 1'b0;
		if (hold_left > 0) begin
			s = 1'b1;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			s = 1'b1;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_mode_left = $urandom_range(10, 80);
			end
			rx_mode_left--;
			case (rx_mode)
				RX_FREE:  s = 1'b0;
				RX_LIGHT: s = ($urandom_range(0, 3) == 0);
				default:  s = ($urandom_range(0, 3) != 0);
			endcase
		end
		result_stall <= s;
	end

	// one instruction transfer, preceded by an idle gap when the burst is used up
	task automatic send_instr(opcode_t f, logic [3:0] d, logic [7:0] o);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(negedge clk) item_valid <= 1'b0;
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		func <= f;
		dest_reg <= d;
		operand <= o;
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic drain_results();
		@(negedge clk) item_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	// mostly well-formed: pointers loaded before indirect access, zeroed regs before jz
	task automatic rand_instr();
		int         pick;
		logic [3:0] a;
		logic [3:0] b;
		logic [7:0] o;
		pick = $urandom_range(0, 99);
		a = 4'($urandom);
		b = 4'($urandom);
		o = 8'($urandom);
		if (pick < 8) begin
			send_instr(OP_MOV0, a, o);
		end else if (pick < 16) begin
			send_instr(OP_MOV1, a, o);
		end else if (pick < 28) begin
			if ($urandom_range(0, 4) != 0)
				send_instr(OP_MOV3, a, 8'($urandom));
			send_instr(OP_MOV2, a, o);
		end else if (pick < 40) begin
			send_instr(OP_MOV3, a, o);
		end else if (pick < 50) begin
			send_instr(OP_ADD, a, o);
		end else if (pick < 58) begin
			send_instr(OP_SUB, a, o);
		end else if (pick < 64) begin
			send_instr(OP_MUL, a, o);
		end else if (pick < 70) begin
			send_instr(OP_MOV4, a, o);
		end else if (pick < 82) begin
			if ($urandom_range(0, 1) != 0)
				send_instr(OP_SUB, a, {a, b});
			send_instr(OP_JZ, a, o);
		end else if (pick < 94) begin
			if ($urandom_range(0, 4) != 0)
				send_instr(OP_MOV3, b, 8'($urandom));
			send_instr(OP_MOV5, a, {o[7:4], b});
		end else begin
			send_instr(opcode_t'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD)), a, o);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		func = '0;
		dest_reg = '0;
		operand = '0;
		result_stall = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// pc wraps backward, then forward jump, then pointer at the top of memory
		send_instr(OP_MOV3, 4'd0, 8'h00);
		send_instr(OP_JZ, 4'd0, 8'h80);
		send_instr(OP_JZ, 4'd0, 8'h7F);
		send_instr(OP_MOV3, 4'd15, 8'hFF);
		send_instr(OP_MOV1, 4'd15, 8'hFF);
		send_instr(OP_MOV2, 4'd15, 8'h0F);
		send_instr(OP_MOV5, 4'd1, 8'h0F);
		send_instr(OP_MOV0, 4'd2, 8'hFF);
		// negative and oversized pointers fault
		send_instr(OP_SUB, 4'd3, 8'hF0);
		send_instr(OP_MOV2, 4'd3, 8'h00);
		send_instr(OP_MOV5, 4'd4, 8'hF3);
		send_instr(OP_ADD, 4'd15, 8'hF0);
		send_instr(OP_MOV2, 4'd15, 8'h00);
		send_instr(OP_JZ, 4'd15, 8'h10);
		// multiply wraps to zero, then the branch on it is taken
		send_instr(OP_MOV3, 4'd5, 8'h80);
		send_instr(OP_MOV4, 4'd6, 8'h50);
		send_instr(OP_MUL, 4'd6, 8'h60);
		send_instr(OP_MUL, 4'd6, 8'h60);
		send_instr(OP_MUL, 4'd6, 8'h60);
		send_instr(OP_JZ, 4'd6, 8'h01);
		send_instr(OP_FIRST_BAD, 4'd0, 8'h00);
		send_instr(OP_LAST_BAD, 4'd15, 8'hFF);
		send_instr(OP_MOV0, 4'd0, 8'h00);
		drain_results();

		// receiver holds off while the sender keeps pushing
		hold_req = 1'b1;
		burst_left = 40;
		repeat (30) rand_instr();

		while (sent < 450)
			rand_instr();
		drain_results();
		hold_req = 1'b1;
		burst_left = 40;
		while (sent < TOTAL_ITEMS)
			rand_instr();

		drain_results();
		repeat (20) @(posedge clk);
		$display("%0d instructions checked, %0d faults, %0d branches taken, %0d memory writes",
			sb.checked, sb.faults, sb.taken, sb.mem_writes);
		$display("input stalled on %0d cycles under random and long output hold-offs",
			in_stall_cycles);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* tiny_cpu_execute_unit.f */
rtl/tce_pkg.sv
rtl/tce_regfile.sv
rtl/tce_dmem.sv
rtl/tiny_cpu_execute_unit.sv
tb/exec_check_pkg.sv
tb/tiny_cpu_execute_unit_tb.sv
